[hdl/rau_pkg.sv]
package rau_pkg;

    localparam int unsigned CMD_W = 3;
    localparam int unsigned MAG_W = 32;
    localparam int unsigned WIDE_W = 64;

    localparam logic [CMD_W-1:0] CMD_NORM = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL1,
        OP_MUL2,
        OP_COMBINE,
        OP_GCD_INIT,
        OP_GCD_STEP,
        OP_GCD_FIN,
        OP_DIV_STEP,
        OP_DIVB_INIT,
        OP_FINISH
    } t_op;

    typedef struct packed {
        logic gcd_done;
        logic div_done;
        logic bad;
    } t_status;

endpackage

[hdl/rau_ctrl.sv]
module rau_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_free,
    input  rau_pkg::t_status i_stat,
    output rau_pkg::t_op     o_op,
    output logic             o_done
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_M2    = 4'd2;
    localparam logic [3:0] S_CMB   = 4'd3;
    localparam logic [3:0] S_GI    = 4'd4;
    localparam logic [3:0] S_GCD   = 4'd5;
    localparam logic [3:0] S_DIVA  = 4'd6;
    localparam logic [3:0] S_DIVB  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_op    = rau_pkg::OP_NONE;
        o_done  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_op    = rau_pkg::OP_LOAD;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.bad) begin
                    n_state = S_DONE;
                end else begin
                    o_op    = rau_pkg::OP_MUL1;
                    n_state = S_M2;
                end
            end
            S_M2: begin
                o_op    = rau_pkg::OP_MUL2;
                n_state = S_CMB;
            end
            S_CMB: begin
                o_op    = rau_pkg::OP_COMBINE;
                n_state = S_GI;
            end
            S_GI: begin
                o_op    = rau_pkg::OP_GCD_INIT;
                n_state = S_GCD;
            end
            S_GCD: begin
                if (i_stat.gcd_done) begin
                    o_op    = rau_pkg::OP_GCD_FIN;
                    n_state = S_DIVA;
                end else begin
                    o_op = rau_pkg::OP_GCD_STEP;
                end
            end
            S_DIVA: begin
                if (i_stat.div_done) begin
                    o_op    = rau_pkg::OP_DIVB_INIT;
                    n_state = S_DIVB;
                end else begin
                    o_op = rau_pkg::OP_DIV_STEP;
                end
            end
            S_DIVB: begin
                if (i_stat.div_done) begin
                    o_op    = rau_pkg::OP_FINISH;
                    n_state = S_DONE;
                end else begin
                    o_op = rau_pkg::OP_DIV_STEP;
                end
            end
            S_DONE: begin
                if (i_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[hdl/rau_dp.sv]
module rau_dp #(
    parameter int unsigned EW = 32
) (
    input  logic                        i_clk,
    input  rau_pkg::t_op                i_op,
    input  logic [rau_pkg::CMD_W-1:0]   i_cmd,
    input  logic [rau_pkg::MAG_W-1:0]   i_n1,
    input  logic [rau_pkg::MAG_W-1:0]   i_d1,
    input  logic [rau_pkg::MAG_W-1:0]   i_n2,
    input  logic [rau_pkg::MAG_W-1:0]   i_d2,
    output rau_pkg::t_status            o_stat,
    output logic [rau_pkg::MAG_W-1:0]   o_num,
    output logic [rau_pkg::MAG_W-2:0]   o_den,
    output logic [1:0]                  o_status
);

    localparam int unsigned WW = rau_pkg::WIDE_W;
    localparam int unsigned MW = rau_pkg::MAG_W;
    localparam logic [WW-1:0] LIM = WW'(1) << (EW - 1);

    logic [MW-1:0] r_a, r_b, r_c, r_d;
    logic          r_s1, r_s2, r_neg, r_bad;
    logic [rau_pkg::CMD_W-1:0] r_cmd;
    logic [WW-1:0] r_t1, r_t2, r_mag, r_den;
    logic [WW-1:0] r_gx, r_gy;
    logic [5:0]    r_gk;
    logic [WW-1:0] r_dq, r_drem, r_ddiv;
    logic [6:0]    r_dcnt;

    function automatic logic [MW:0] smag(input logic [MW-1:0] raw);
        logic [MW-1:0] v;
        logic          n;
        v = raw & MW'((64'd1 << EW) - 64'd1);
        n = v[EW-1];
        return {n, n ? MW'((64'd1 << EW) - 64'(v)) : v};
    endfunction

    logic [MW:0] w_n1, w_d1, w_n2, w_d2;
    logic [rau_pkg::CMD_W-1:0] w_cmd;
    logic [WW:0]   w_dtry;
    logic [WW-1:0] w_gcd;
    logic          w_addsub;

    assign w_n1 = smag(i_n1);
    assign w_d1 = smag(i_d1);
    assign w_n2 = smag(i_n2);
    assign w_d2 = smag(i_d2);
    assign w_cmd = (i_cmd >= rau_pkg::CMD_ADD && i_cmd <= rau_pkg::CMD_DIV) ? i_cmd
                                                                       : rau_pkg::CMD_NORM;
    assign w_dtry   = {r_drem[WW-1:0], r_dq[WW-1]} - {1'b0, r_ddiv};
    assign w_gcd    = (r_gx | r_gy) << r_gk;
    assign w_addsub = (r_cmd == rau_pkg::CMD_ADD || r_cmd == rau_pkg::CMD_SUB);

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            rau_pkg::OP_LOAD: begin
                r_cmd <= w_cmd;
                r_a   <= w_n1[MW-1:0];
                r_b   <= w_d1[MW-1:0];
                r_c   <= w_n2[MW-1:0];
                r_d   <= w_d2[MW-1:0];
                r_s1  <= w_n1[MW] ^ w_d1[MW];
                r_s2  <= (w_n2[MW] ^ w_d2[MW]) ^ (w_cmd == rau_pkg::CMD_SUB);
                r_bad <= (w_d1[MW-1:0] == '0)
                      || (w_cmd != rau_pkg::CMD_NORM && w_d2[MW-1:0] == '0)
                      || (w_cmd == rau_pkg::CMD_DIV && w_n2[MW-1:0] == '0);
            end
            rau_pkg::OP_MUL1: begin
                unique case (r_cmd)
                    rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
                        r_t1 <= WW'(r_a) * WW'(r_d);
                        r_t2 <= WW'(r_c) * WW'(r_b);
                    end
                    rau_pkg::CMD_MUL: begin
                        r_t1 <= WW'(r_a) * WW'(r_c);
                        r_t2 <= '0;
                    end
                    rau_pkg::CMD_DIV: begin
                        r_t1 <= WW'(r_a) * WW'(r_d);
                        r_t2 <= '0;
                    end
                    default: begin
                        r_t1 <= WW'(r_a);
                        r_t2 <= '0;
                    end
                endcase
            end
            rau_pkg::OP_MUL2: begin
                r_den <= (r_cmd == rau_pkg::CMD_NORM) ? WW'(r_b)
                       : WW'(r_b) * WW'((r_cmd == rau_pkg::CMD_DIV) ? r_c : r_d);
            end
            rau_pkg::OP_COMBINE: begin
                if (w_addsub) begin
                    if (r_s1 == r_s2) begin
                        r_neg <= r_s1;
                        r_mag <= r_t1 + r_t2;
                    end else if (r_t1 >= r_t2) begin
                        r_neg <= r_s1;
                        r_mag <= r_t1 - r_t2;
                    end else begin
                        r_neg <= r_s2;
                        r_mag <= r_t2 - r_t1;
                    end
                end else begin
                    r_neg <= (r_cmd == rau_pkg::CMD_NORM) ? r_s1 : (r_s1 ^ r_s2);
                    r_mag <= r_t1;
                end
            end
            rau_pkg::OP_GCD_INIT: begin
                r_gx <= r_mag;
                r_gy <= r_den;
                r_gk <= '0;
            end
            rau_pkg::OP_GCD_STEP: begin
                if (!r_gx[0] && !r_gy[0]) begin
                    r_gx <= r_gx >> 1;
                    r_gy <= r_gy >> 1;
                    r_gk <= r_gk + 6'd1;
                end else if (!r_gx[0]) begin
                    r_gx <= r_gx >> 1;
                end else if (!r_gy[0]) begin
                    r_gy <= r_gy >> 1;
                end else if (r_gx >= r_gy) begin
                    r_gx <= (r_gx - r_gy) >> 1;
                end else begin
                    r_gy <= (r_gy - r_gx) >> 1;
                end
            end
            rau_pkg::OP_GCD_FIN: begin
                r_ddiv <= w_gcd;
                r_dq   <= r_mag;
                r_drem <= '0;
                r_dcnt <= '0;
            end
            rau_pkg::OP_DIV_STEP: begin
                if (!w_dtry[WW]) begin
                    r_drem <= w_dtry[WW-1:0];
                    r_dq   <= {r_dq[WW-2:0], 1'b1};
                end else begin
                    r_drem <= {r_drem[WW-2:0], r_dq[WW-1]};
                    r_dq   <= {r_dq[WW-2:0], 1'b0};
                end
                r_dcnt <= r_dcnt + 7'd1;
            end
            rau_pkg::OP_DIVB_INIT: begin
                r_mag  <= r_dq;
                r_dq   <= r_den;
                r_drem <= '0;
                r_dcnt <= '0;
            end
            rau_pkg::OP_FINISH: begin
                r_den <= r_dq;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.gcd_done = (r_gx == '0) || (r_gy == '0);
    assign o_stat.div_done = (r_dcnt == 7'd64);
    assign o_stat.bad      = r_bad;

    logic w_ovf;
    logic w_neg;
    logic [WW-1:0] w_fden;
    assign w_neg  = r_neg && r_mag != '0;
    assign w_fden = (r_mag == '0) ? WW'(1) : r_den;
    assign w_ovf  = (w_fden > LIM - WW'(1)) ||
                    (w_neg ? (r_mag > LIM) : (r_mag > LIM - WW'(1)));

    always_comb begin
        if (r_bad) begin
            o_status = rau_pkg::ST_ZERO;
            o_num    = '0;
            o_den    = '0;
        end else if (w_ovf) begin
            o_status = rau_pkg::ST_OVF;
            o_num    = '0;
            o_den    = '0;
        end else begin
            o_status = rau_pkg::ST_OK;
            o_num    = w_neg ? MW'(-r_mag) : MW'(r_mag);
            o_den    = w_fden[MW-2:0];
        end
    end

endmodule

[hdl/rational_arithmetic_unit_top.sv]
// Exact fraction unit: add, subtract, multiply, divide or normalize two signed
// fractions and return the result in lowest terms with a positive denominator.
// One item is in flight at a time and s_axis_tready stays low while it runs.
// A valid item runs a binary gcd loop and two 64-step restoring divisions, which
// divide the magnitude and the denominator by the gcd, before it reaches the
// output register. An item with a zero denominator or a zero divisor skips them.
// The result sits in an output register, so a new transfer may be taken while
// a finished result waits; a result that finds the register full is held.
module rational_arithmetic_unit_top #(
    parameter int unsigned WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command[2:0], first_num[34:3], first_den[66:35], second_num[98:67],
    // second_den[130:99], zero fill to 136
    input  logic [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_num[31:0], result_den[62:32], status[64:63], zero fill to 72
    output logic [71:0]  m_axis_tdata
);

    localparam int unsigned EW = (WIDTH > 32) ? 32 : WIDTH;

    rau_pkg::t_op     w_op;
    rau_pkg::t_status w_stat;
    logic             w_done;
    logic             w_free;
    logic             r_busy;
    logic [31:0]      w_num;
    logic [30:0]      w_den;
    logic [1:0]       w_st;
    logic             r_ovalid;
    logic [71:0]      r_odata;
    logic             w_start;

    assign s_axis_tready = !r_busy;
    assign w_start       = s_axis_tvalid && s_axis_tready;
    assign w_free        = !r_ovalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_start) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
            if (w_done) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_odata <= {7'd0, w_st, w_den, w_num};
        end
    end

    rau_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_free  (w_free),
        .i_stat  (w_stat),
        .o_op    (w_op),
        .o_done  (w_done)
    );

    rau_dp #(.EW(EW)) u_dp (
        .i_clk    (i_clk),
        .i_op     (w_op),
        .i_cmd    (s_axis_tdata[2:0]),
        .i_n1     (s_axis_tdata[34:3]),
        .i_d1     (s_axis_tdata[66:35]),
        .i_n2     (s_axis_tdata[98:67]),
        .i_d2     (s_axis_tdata[130:99]),
        .o_stat   (w_stat),
        .o_num    (w_num),
        .o_den    (w_den),
        .o_status (w_st)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    a_ok_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[64:63] != rau_pkg::ST_OK |-> m_axis_tdata[62:0] == '0)
        else $error("error result not zeroed");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> !s_axis_tready)
        else $error("second item taken while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");

endmodule

[test/rational_arithmetic_unit_checker.sv]
module rational_arithmetic_unit_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [135:0] i_in_data,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [71:0]  i_out_data,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] num;
        logic [30:0]        den;
        logic [1:0]         status;
    } t_fraction;

    t_fraction expected_fractions[$];

    function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic t_fraction reduce_fraction(input logic [135:0] item);
        logic [2:0]  cmd;
        logic        n1n, d1n, n2n, d2n, s1, s2, neg;
        logic [63:0] a, b, c, d, mag, den, g, bg, dg, t1, t2;
        t_fraction   r;
        cmd = item[2:0];
        n1n = item[34];
        d1n = item[66];
        n2n = item[98];
        d2n = item[130];
        a = n1n ? 64'(-$signed(item[34:3])) & 64'hFFFF_FFFF : 64'(item[34:3]);
        b = d1n ? 64'(-$signed(item[66:35])) & 64'hFFFF_FFFF : 64'(item[66:35]);
        c = n2n ? 64'(-$signed(item[98:67])) & 64'hFFFF_FFFF : 64'(item[98:67]);
        d = d2n ? 64'(-$signed(item[130:99])) & 64'hFFFF_FFFF : 64'(item[130:99]);
        s1 = n1n != d1n;
        s2 = n2n != d2n;
        r = '0;
        if (cmd > rau_pkg::CMD_DIV)
            cmd = rau_pkg::CMD_NORM;
        if (b == 0 || (cmd != rau_pkg::CMD_NORM && d == 0)
                || (cmd == rau_pkg::CMD_DIV && c == 0)) begin
            r.status = rau_pkg::ST_ZERO;
            return r;
        end
        case (cmd)
            rau_pkg::CMD_NORM: begin
                neg = s1;
                mag = a;
                den = b;
            end
            rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
                if (cmd == rau_pkg::CMD_SUB)
                    s2 = !s2;
                g = gcd64(b, d);
                bg = b / g;
                dg = d / g;
                t1 = a * dg;
                t2 = c * bg;
                den = bg * d;
                if (s1 == s2) begin
                    neg = s1;
                    mag = t1 + t2;
                end else if (t1 >= t2) begin
                    neg = s1;
                    mag = t1 - t2;
                end else begin
                    neg = s2;
                    mag = t2 - t1;
                end
            end
            rau_pkg::CMD_MUL: begin
                neg = s1 != s2;
                mag = a * c;
                den = b * d;
            end
            default: begin
                neg = s1 != s2;
                mag = a * d;
                den = b * c;
            end
        endcase
        g = gcd64(mag, den);
        mag = mag / g;
        den = den / g;
        if (mag == 0) begin
            neg = 1'b0;
            den = 1;
        end
        if (den > 64'h7FFF_FFFF || (neg ? mag > 64'h8000_0000 : mag > 64'h7FFF_FFFF)) begin
            r.status = rau_pkg::ST_OVF;
            return r;
        end
        r.num = neg ? -mag[31:0] : mag[31:0];
        r.den = den[30:0];
        r.status = rau_pkg::ST_OK;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_fraction got, want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_results_seen <= 0;
            o_pending <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                expected_fractions.push_back(reduce_fraction(i_in_data));
            if (i_out_valid && i_out_ready) begin
                o_results_seen <= o_results_seen + 1;
                got.num = i_out_data[31:0];
                got.den = i_out_data[62:32];
                got.status = i_out_data[64:63];
                if (expected_fractions.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_fractions.pop_front();
                    if (got.num !== want.num || got.den !== want.den
                            || got.status !== want.status) begin
                        $display("%0t: expected %0d/%0d st %0d, got %0d/%0d st %0d", $time,
                                 want.num, want.den, want.status,
                                 got.num, got.den, got.status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= expected_fractions.size();
        end
    end
endmodule

[test/rational_arithmetic_unit_top_test.sv]
module rational_arithmetic_unit_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;
    int           fail_count, pending, results_seen;
    int           items_sent = 0;
    int           idle_cycles = 0;
    logic         steady = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    rational_arithmetic_unit_top dut (.*);

    rational_arithmetic_unit_checker checker_i (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending), .o_results_seen(results_seen)
    );

    always @(negedge i_clk)
        m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= 26);

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("rational_arithmetic_unit_top_test: FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] pick_value(input int mode);
        case (mode)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'd0;
            4: return 32'd1;
            5: return $urandom;
            6: return 32'($signed($urandom_range(200)) - 100);
            default: return 32'($signed($urandom_range(4000)) - 2000);
        endcase
    endfunction

    task automatic send_fraction(input logic [2:0] cmd, input logic [31:0] n1,
                                 input logic [31:0] d1, input logic [31:0] n2,
                                 input logic [31:0] d2);
        while (!steady && $urandom_range(99) < 26) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata <= {5'd0, d2, n2, d1, n1, cmd};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        items_sent++;
    endtask

    initial begin
        logic [2:0] op;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int k = 0; k <= 7; k++)
            send_fraction(3'(k), 32'd6, -32'sd4, 32'd3, 32'd9);
        send_fraction(rau_pkg::CMD_NORM, 32'd5, 32'd0, 32'd1, 32'd0);
        send_fraction(rau_pkg::CMD_ADD, 32'd1, 32'd2, 32'd1, 32'd0);
        send_fraction(rau_pkg::CMD_DIV, 32'd1, 32'd2, 32'd0, 32'd3);
        send_fraction(rau_pkg::CMD_MUL, 32'd0, -32'sd7, 32'd5, 32'd3);
        send_fraction(rau_pkg::CMD_NORM, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_fraction(rau_pkg::CMD_NORM, 32'h8000_0000, 32'd1, 32'd0, 32'd0);
        send_fraction(rau_pkg::CMD_NORM, 32'd1, 32'h8000_0000, 32'd0, 32'd0);
        send_fraction(rau_pkg::CMD_NORM, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_fraction(rau_pkg::CMD_MUL, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1);
        send_fraction(rau_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'd1, 32'd1, 32'd1);
        send_fraction(rau_pkg::CMD_SUB, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
        send_fraction(rau_pkg::CMD_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h7FFF_FFFF);
        send_fraction(rau_pkg::CMD_ADD, 32'd1, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFE);
        for (int i = 0; i < 750; i++) begin
            steady = (i >= 300 && i < 400);
            op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
                                           : 3'($urandom_range(4));
            send_fraction(op, pick_value($urandom_range(7)), pick_value($urandom_range(7)),
                          pick_value($urandom_range(7)), pick_value($urandom_range(7)));
        end
        s_axis_tvalid <= 1'b0;
        steady = 1'b0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("sent %0d fraction items across all commands, got %0d results",
                 items_sent, results_seen);
        if (fail_count == 0 && pending == 0)
            $display("rational_arithmetic_unit_top_test: PASS");
        else
            $display("rational_arithmetic_unit_top_test: FAIL");
        $finish;
    end
endmodule

[sim.f]
hdl/rau_pkg.sv
hdl/rau_ctrl.sv
hdl/rau_dp.sv
hdl/rational_arithmetic_unit_top.sv
test/rational_arithmetic_unit_checker.sv
test/rational_arithmetic_unit_top_test.sv
